@@ hw/rtl/kti_pkg.sv @@
// Shared constants, codes and control types for the keyframe track interpolator.
// Used by the interfaces, the key cell and the top level; depends on nothing.
`timescale 1ns / 1ps
package kti_pkg;

	localparam int TOL_W      = 31;
	localparam int REQ_W      = 2;
	localparam int STAT_W     = 2;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LINEAR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_STEP   = 2'd2;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// Wrap modes.
	localparam logic [MODE_W-1:0] WRAP_CLAMP    = 2'd0;
	localparam logic [MODE_W-1:0] WRAP_REPEAT   = 2'd1;
	localparam logic [MODE_W-1:0] WRAP_PINGPONG = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TOL         = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_BEFORE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_AFTER  = 2'd2;

	// Command broadcast to every key cell.
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_SCAN_ADD,
		CMD_SCAN_EVAL,
		CMD_MERGE,
		CMD_INSERT
	} cmd_op_t;

	// Control part of the search probe that walks down the cell chain.
	typedef struct packed {
		logic live;
		logic done;
		logic is_merge;
	} probe_ctl_t;

endpackage

@@ hw/rtl/kti_if.sv @@
// Channel interfaces of the keyframe track interpolator: request, result and configuration.
// Depends on kti_pkg for field widths.
`timescale 1ns / 1ps
interface kti_req_if #(parameter int DATA_WIDTH = 32);
	import kti_pkg::*;
	logic                         valid;
	logic                         ready;
	logic [REQ_W-1:0]             req_type;
	logic signed [DATA_WIDTH-1:0] key_time;
	logic signed [DATA_WIDTH-1:0] key_value;
	modport source(output valid, req_type, key_time, key_value, input ready);
	modport sink(input valid, req_type, key_time, key_value, output ready);
endinterface

interface kti_res_if #(parameter int DATA_WIDTH = 32, parameter int CNT_W = 7);
	import kti_pkg::*;
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] result_value;
	logic [STAT_W-1:0]            status;
	logic [CNT_W-1:0]             key_count;
	modport source(output valid, result_value, status, key_count, input ready);
	modport sink(input valid, result_value, status, key_count, output ready);
endinterface

interface kti_cfg_if;
	import kti_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ hw/rtl/kti_cell.sv @@
// One key cell of the sorted keyframe chain: holds one (time, value) pair and one probe stage.
// Depends on kti_pkg for the command and probe types.
`timescale 1ns / 1ps
module kti_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int IDX_W      = 6,
	parameter int CNT_W      = 7,
	parameter int CELL_IDX   = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  kti_pkg::cmd_op_t             cmd_op,
	input  logic [IDX_W-1:0]             cmd_pos,
	input  logic signed [DATA_WIDTH-1:0] cmd_time,
	input  logic signed [DATA_WIDTH-1:0] cmd_value,
	input  logic [kti_pkg::TOL_W-1:0]    tol,
	input  logic [CNT_W-1:0]             count,
	input  logic signed [DATA_WIDTH-1:0] left_time,
	input  logic signed [DATA_WIDTH-1:0] left_value,
	input  logic signed [DATA_WIDTH-1:0] right_time,
	input  logic signed [DATA_WIDTH-1:0] right_value,
	input  kti_pkg::probe_ctl_t          prb_in,
	input  logic [IDX_W-1:0]             prb_pos_in,
	input  logic signed [DATA_WIDTH-1:0] prb_t0_in,
	input  logic signed [DATA_WIDTH-1:0] prb_v0_in,
	input  logic signed [DATA_WIDTH-1:0] prb_t1_in,
	input  logic signed [DATA_WIDTH-1:0] prb_v1_in,
	output kti_pkg::probe_ctl_t          prb_out,
	output logic [IDX_W-1:0]             prb_pos_out,
	output logic signed [DATA_WIDTH-1:0] prb_t0_out,
	output logic signed [DATA_WIDTH-1:0] prb_v0_out,
	output logic signed [DATA_WIDTH-1:0] prb_t1_out,
	output logic signed [DATA_WIDTH-1:0] prb_v1_out,
	output logic signed [DATA_WIDTH-1:0] key_time,
	output logic signed [DATA_WIDTH-1:0] key_value
);
	import kti_pkg::*;

	localparam int CMP_W = (DATA_WIDTH + 1 > TOL_W) ? DATA_WIDTH + 1 : TOL_W;
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic signed [DATA_WIDTH-1:0] time_q;
	logic signed [DATA_WIDTH-1:0] value_q;
	probe_ctl_t                   prb_q;
	logic [IDX_W-1:0]             pos_q;
	logic signed [DATA_WIDTH-1:0] t0_q, v0_q, t1_q, v1_q;

	logic                         own_ok, is_last;
	logic signed [DATA_WIDTH:0]   diff;
	logic [DATA_WIDTH:0]          abs_diff;
	logic                         merge_hit, below_t, claim, take;

	always_comb begin
		own_ok    = CNT_W'(CELL_IDX) < count;
		is_last   = CNT_W'(CELL_IDX + 1) == count;
		diff      = {time_q[DATA_WIDTH-1], time_q} - {cmd_time[DATA_WIDTH-1], cmd_time};
		abs_diff  = diff[DATA_WIDTH] ? $unsigned(-diff) : $unsigned(diff);
		merge_hit = CMP_W'(abs_diff) <= CMP_W'(tol);
		below_t   = time_q < cmd_time;
		case (cmd_op)
			CMD_SCAN_ADD:  claim = merge_hit || !below_t;
			CMD_SCAN_EVAL: claim = is_last || (right_time >= cmd_time);
			default:       claim = 1'b0;
		endcase
		take = prb_in.live && !prb_in.done && own_ok && claim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prb_q <= '0;
		end else begin
			prb_q.live     <= prb_in.live;
			prb_q.done     <= prb_in.done || take;
			prb_q.is_merge <= take ? merge_hit : prb_in.is_merge;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pos_q <= MY_IDX;
			t0_q  <= time_q;
			v0_q  <= value_q;
			t1_q  <= is_last ? time_q : right_time;
			v1_q  <= is_last ? value_q : right_value;
		end else begin
			pos_q <= prb_pos_in;
			t0_q  <= prb_t0_in;
			v0_q  <= prb_v0_in;
			t1_q  <= prb_t1_in;
			v1_q  <= prb_v1_in;
		end
		case (cmd_op)
			CMD_MERGE: begin
				if (cmd_pos == MY_IDX) value_q <= cmd_value;
			end
			CMD_INSERT: begin
				if (cmd_pos == MY_IDX) begin
					time_q  <= cmd_time;
					value_q <= cmd_value;
				end else if (MY_IDX > cmd_pos) begin
					time_q  <= left_time;
					value_q <= left_value;
				end
			end
			default: ;
		endcase
	end

	assign prb_out     = prb_q;
	assign prb_pos_out = pos_q;
	assign prb_t0_out  = t0_q;
	assign prb_v0_out  = v0_q;
	assign prb_t1_out  = t1_q;
	assign prb_v1_out  = v1_q;
	assign key_time    = time_q;
	assign key_value   = value_q;

endmodule

@@ hw/rtl/kti_div.sv @@
// Radix-2 restoring divider for unsigned operands, one quotient bit per cycle.
// Standalone; shared by the wrap and blend-weight paths of the top level.
`timescale 1ns / 1ps
module kti_div #(
	parameter int NUM_W = 49,
	parameter int DEN_W = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);
	localparam int STEP_W = $clog2(NUM_W + 1);

	logic              busy_q, done_q;
	logic [STEP_W-1:0] steps_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  rem_q, den_q;
	logic [DEN_W:0]    shifted;
	logic [DEN_W+1:0]  trial;
	logic              fits;

	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		trial   = {1'b0, shifted} - {2'b00, den_q};
		fits    = !trial[DEN_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				steps_q <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				steps_q <= steps_q - 1'b1;
				if (steps_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

@@ hw/rtl/keyframe_track_interpolator.sv @@
// Keyframe track interpolator: a sorted chain of MAX_KEYS key cells, a serial divider, control.
// An add walks the probe down the chain, but not past the last key, on an empty table or for an
// unused code; an evaluate on a non-empty table also walks it, after a wrap division where one
// is needed, and a linear blend then adds the weight division and the multiply.
// One request at a time; the probe walk, the divider and result-side hold-off set the pace.
// Asynchronous active-low reset empties the table and restores tolerance 1 and clamp modes.
`timescale 1ns / 1ps
module keyframe_track_interpolator #(
	parameter int MAX_KEYS   = 64,
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input logic  clk,
	input logic  arst_n,
	kti_req_if.sink   req,
	kti_res_if.source res,
	kti_cfg_if.sink   cfg
);
	import kti_pkg::*;

	localparam int DW     = DATA_WIDTH;
	localparam int IDX_W  = $clog2(MAX_KEYS);
	localparam int CNT_W  = $clog2(MAX_KEYS + 1);
	localparam int NUM_W  = DW + FRAC_BITS + 1;
	localparam int DEN_W  = DW + 1;
	localparam int ONE_W  = FRAC_BITS + 1;
	localparam int PROD_W = DW + ONE_W + 1;
	localparam int ACC_W  = PROD_W + 1;
	localparam int CMP_W  = (DW + 1 > TOL_W) ? DW + 1 : TOL_W;
	localparam logic [ONE_W-1:0] ONE  = ONE_W'(1) << FRAC_BITS;
	localparam logic [ACC_W-1:0] HALF = (ACC_W'(1) << FRAC_BITS) >> 1;
	localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_KEYS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WDIV,
		S_SCAN,
		S_BDIV,
		S_MUL,
		S_SUM,
		S_OUT
	} state_t;

	state_t state_q;

	// Table bookkeeping. The first key time is read straight from cell zero; the last key
	// time is mirrored here because its cell moves as keys come in.
	logic [CNT_W-1:0]      count_q;
	logic signed [DW-1:0]  last_q;
	logic [TOL_W-1:0]      tol_q;
	logic [MODE_W-1:0]     wb_q, wa_q;

	// Request being worked on. t_q is the (possibly wrapped or clamped) query time that the cells see.
	logic signed [DW-1:0]  t_q, v_q;
	logic                  step_q, below_q, pp_q;
	cmd_op_t               cmd_op_q;
	logic [IDX_W-1:0]      cmd_pos_q;
	logic                  launch_q;

	// Blend operands and products.
	logic signed [DW-1:0]     v0_q, v1_q;
	logic [ONE_W-1:0]         w0_q;
	logic signed [PROD_W-1:0] p0_q, p1_q;

	// Divider hookup.
	logic             div_start_q, div_done;
	logic [NUM_W-1:0] div_num_q, div_quo;
	logic [DEN_W-1:0] div_den_q, div_rem;

	// Pending result, then the output register that parts the result side from the work.
	logic signed [DW-1:0] pres_val_q, out_val_q;
	logic [STAT_W-1:0]    pres_stat_q, out_stat_q;
	logic [CNT_W-1:0]     out_cnt_q;
	logic                 out_valid_q;

	// Cell chain wiring.
	logic signed [DW-1:0] key_t [MAX_KEYS];
	logic signed [DW-1:0] key_v [MAX_KEYS];
	probe_ctl_t           prb_ctl [MAX_KEYS+1];
	logic [IDX_W-1:0]     prb_pos [MAX_KEYS+1];
	logic signed [DW-1:0] prb_t0 [MAX_KEYS+1];
	logic signed [DW-1:0] prb_v0 [MAX_KEYS+1];
	logic signed [DW-1:0] prb_t1 [MAX_KEYS+1];
	logic signed [DW-1:0] prb_v1 [MAX_KEYS+1];

	// The probe enters at cell zero for one cycle. Each cell it passes either claims it
	// (the first cell that matches the request) or hands it on unchanged.
	assign prb_ctl[0] = '{live: launch_q, done: 1'b0, is_merge: 1'b0};
	assign prb_pos[0] = '0;
	assign prb_t0[0]  = '0;
	assign prb_v0[0]  = '0;
	assign prb_t1[0]  = '0;
	assign prb_v1[0]  = '0;

	for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
		logic signed [DW-1:0] lt_w, lv_w, rt_w, rv_w;
		if (i == 0) begin : g_left_edge
			assign lt_w = '0;
			assign lv_w = '0;
		end else begin : g_left
			assign lt_w = key_t[i-1];
			assign lv_w = key_v[i-1];
		end
		if (i == MAX_KEYS - 1) begin : g_right_edge
			assign rt_w = '0;
			assign rv_w = '0;
		end else begin : g_right
			assign rt_w = key_t[i+1];
			assign rv_w = key_v[i+1];
		end
		kti_cell #(
			.DATA_WIDTH(DW),
			.IDX_W     (IDX_W),
			.CNT_W     (CNT_W),
			.CELL_IDX  (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd_op     (cmd_op_q),
			.cmd_pos    (cmd_pos_q),
			.cmd_time   (t_q),
			.cmd_value  (v_q),
			.tol        (tol_q),
			.count      (count_q),
			.left_time  (lt_w),
			.left_value (lv_w),
			.right_time (rt_w),
			.right_value(rv_w),
			.prb_in     (prb_ctl[i]),
			.prb_pos_in (prb_pos[i]),
			.prb_t0_in  (prb_t0[i]),
			.prb_v0_in  (prb_v0[i]),
			.prb_t1_in  (prb_t1[i]),
			.prb_v1_in  (prb_v1[i]),
			.prb_out    (prb_ctl[i+1]),
			.prb_pos_out(prb_pos[i+1]),
			.prb_t0_out (prb_t0[i+1]),
			.prb_v0_out (prb_v0[i+1]),
			.prb_t1_out (prb_t1[i+1]),
			.prb_v1_out (prb_v1[i+1]),
			.key_time   (key_t[i]),
			.key_value  (key_v[i])
		);
	end

	kti_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num   (div_num_q),
		.den   (div_den_q),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	// Decisions on the incoming beat and on the probe as it leaves the chain.
	logic signed [DW-1:0] first_t, in_t, wrap_t;
	logic                 below_in, above_in, span_small, wrap_on, over_merge, q_odd;
	logic [MODE_W-1:0]    mode_sel;
	logic signed [DW:0]   span, dmag, over_d, den_b, diff_b, wrap_sum;
	logic [DEN_W-1:0]     span_u, r_w;
	logic [NUM_W-1:0]     num_b;
	logic [ONE_W-1:0]     w1;
	logic signed [ACC_W-1:0] acc, acc_sh;
	logic signed [DW-1:0] sat_val;
	logic                 cfg_fire, req_fire;

	always_comb begin
		first_t    = key_t[0];
		in_t       = req.key_time;
		below_in   = in_t < first_t;
		above_in   = in_t > last_q;
		span       = {last_q[DW-1], last_q} - {first_t[DW-1], first_t};
		span_u     = $unsigned(span);
		span_small = CMP_W'(span_u) <= CMP_W'(tol_q);
		mode_sel   = below_in ? wb_q : wa_q;
		// A mode code that means nothing behaves as clamp.
		wrap_on    = !span_small && (mode_sel == WRAP_REPEAT || mode_sel == WRAP_PINGPONG);
		dmag       = below_in ? ({first_t[DW-1], first_t} - {in_t[DW-1], in_t})
		                      : ({in_t[DW-1], in_t} - {first_t[DW-1], first_t});
		over_d     = {in_t[DW-1], in_t} - {last_q[DW-1], last_q};
		over_merge = CMP_W'($unsigned(over_d)) <= CMP_W'(tol_q);

		// Floor modulo from the magnitude division. Below the span the dividend is
		// negative, so a nonzero remainder folds over and the quotient parity flips.
		if (below_q && div_rem != '0) begin
			r_w   = span_u - div_rem;
			q_odd = !div_quo[0];
		end else begin
			r_w   = div_rem;
			q_odd = div_quo[0];
		end
		wrap_sum = {first_t[DW-1], first_t} + $signed(pp_q && q_odd ? span_u - r_w : r_w);
		wrap_t   = wrap_sum[DW-1:0];

		// Weight of the left key: round((t1 - t) * one / (t1 - t0)), both terms non-negative.
		den_b  = {prb_t1[MAX_KEYS][DW-1], prb_t1[MAX_KEYS]}
		       - {prb_t0[MAX_KEYS][DW-1], prb_t0[MAX_KEYS]};
		diff_b = {prb_t1[MAX_KEYS][DW-1], prb_t1[MAX_KEYS]} - {t_q[DW-1], t_q};
		num_b  = (NUM_W'($unsigned(diff_b)) << FRAC_BITS) + NUM_W'($unsigned(den_b) >> 1);

		w1     = ONE - w0_q;
		acc    = ACC_W'(p0_q) + ACC_W'(p1_q) + $signed(HALF);
		acc_sh = acc >>> FRAC_BITS;
		if (acc_sh[ACC_W-1:DW-1] == '0 || acc_sh[ACC_W-1:DW-1] == '1) begin
			sat_val = acc_sh[DW-1:0];
		end else if (acc_sh[ACC_W-1]) begin
			sat_val = {1'b1, {(DW-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(DW-1){1'b1}}};
		end

		cfg_fire = cfg.valid && cfg.ready;
		req_fire = req.valid && req.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cmd_op_q    <= CMD_NONE;
			launch_q    <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			tol_q       <= TOL_W'(1);
			wb_q        <= WRAP_CLAMP;
			wa_q        <= WRAP_CLAMP;
		end else begin
			launch_q    <= 1'b0;
			div_start_q <= 1'b0;

			if (cfg_fire) begin
				case (cfg.index)
					REG_TOL:         tol_q <= cfg.data[TOL_W-1:0];
					REG_WRAP_BEFORE: wb_q  <= cfg.data[MODE_W-1:0];
					REG_WRAP_AFTER:  wa_q  <= cfg.data[MODE_W-1:0];
					default: ;
				endcase
			end

			// The output register empties here unless S_OUT refills it in the same cycle.
			if (out_valid_q && res.ready && state_q != S_OUT) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					// The command is already idle here; S_OUT clears it on the way out.
					if (req_fire) begin
						t_q         <= in_t;
						v_q         <= req.key_value;
						step_q      <= req.req_type == REQ_STEP;
						pres_val_q  <= '0;
						pres_stat_q <= ST_OK;
						case (req.req_type)
							REQ_ADD: begin
								if (count_q == '0) begin
									cmd_op_q  <= CMD_INSERT;
									cmd_pos_q <= '0;
									count_q   <= count_q + 1'b1;
									last_q    <= in_t;
									state_q   <= S_OUT;
								end else if (above_in) begin
									// Past the last key: merge into it, append, or report a full table; no search.
									if (over_merge) begin
										cmd_op_q  <= CMD_MERGE;
										cmd_pos_q <= IDX_W'(count_q - 1'b1);
									end else if (count_q == FULL) begin
										pres_stat_q <= ST_FULL;
									end else begin
										cmd_op_q  <= CMD_INSERT;
										cmd_pos_q <= count_q[IDX_W-1:0];
										count_q   <= count_q + 1'b1;
										last_q    <= in_t;
									end
									state_q <= S_OUT;
								end else begin
									cmd_op_q <= CMD_SCAN_ADD;
									launch_q <= 1'b1;
									state_q  <= S_SCAN;
								end
							end
							REQ_LINEAR, REQ_STEP: begin
								if (count_q == '0) begin
									pres_stat_q <= ST_EMPTY;
									state_q     <= S_OUT;
								end else if ((below_in || above_in) && wrap_on) begin
									div_num_q   <= NUM_W'($unsigned(dmag));
									div_den_q   <= span_u;
									div_start_q <= 1'b1;
									below_q     <= below_in;
									pp_q        <= mode_sel == WRAP_PINGPONG;
									state_q     <= S_WDIV;
								end else begin
									// In range, clamp, or a span too short to wrap over.
									if (below_in) t_q <= first_t;
									else if (above_in) t_q <= last_q;
									cmd_op_q <= CMD_SCAN_EVAL;
									launch_q <= 1'b1;
									state_q  <= S_SCAN;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end

				S_WDIV: begin
					if (div_done) begin
						t_q      <= wrap_t;
						cmd_op_q <= CMD_SCAN_EVAL;
						launch_q <= 1'b1;
						state_q  <= S_SCAN;
					end
				end

				S_SCAN: begin
					if (prb_ctl[MAX_KEYS].live) begin
						if (cmd_op_q == CMD_SCAN_ADD) begin
							if (prb_ctl[MAX_KEYS].is_merge) begin
								cmd_op_q  <= CMD_MERGE;
								cmd_pos_q <= prb_pos[MAX_KEYS];
							end else if (count_q == FULL) begin
								cmd_op_q    <= CMD_NONE;
								pres_stat_q <= ST_FULL;
							end else begin
								cmd_op_q  <= CMD_INSERT;
								cmd_pos_q <= prb_pos[MAX_KEYS];
								count_q   <= count_q + 1'b1;
							end
							state_q <= S_OUT;
						end else begin
							cmd_op_q <= CMD_NONE;
							v0_q     <= prb_v0[MAX_KEYS];
							v1_q     <= prb_v1[MAX_KEYS];
							if (step_q) begin
								pres_val_q <= (t_q == prb_t1[MAX_KEYS]) ? prb_v1[MAX_KEYS]
								                                        : prb_v0[MAX_KEYS];
								state_q    <= S_OUT;
							end else if (prb_t0[MAX_KEYS] == prb_t1[MAX_KEYS]) begin
								pres_val_q <= prb_v0[MAX_KEYS];
								state_q    <= S_OUT;
							end else begin
								div_num_q   <= num_b;
								div_den_q   <= $unsigned(den_b);
								div_start_q <= 1'b1;
								state_q     <= S_BDIV;
							end
						end
					end
				end

				S_BDIV: begin
					if (div_done) begin
						w0_q    <= div_quo[ONE_W-1:0];
						state_q <= S_MUL;
					end
				end

				S_MUL: begin
					p0_q    <= v0_q * $signed({1'b0, w0_q});
					p1_q    <= v1_q * $signed({1'b0, w1});
					state_q <= S_SUM;
				end

				S_SUM: begin
					pres_val_q <= sat_val;
					state_q    <= S_OUT;
				end

				S_OUT: begin
					cmd_op_q <= CMD_NONE;
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						out_val_q   <= pres_val_q;
						out_stat_q  <= pres_stat_q;
						out_cnt_q   <= count_q;
						state_q     <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready        = state_q == S_IDLE;
	assign cfg.ready        = 1'b1;
	assign res.valid        = out_valid_q;
	assign res.result_value = out_val_q;
	assign res.status       = out_stat_q;
	assign res.key_count    = out_cnt_q;

	// The table never holds more keys than it has cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("key count above table size");

	// The divider only finishes while the controller waits for it.
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_WDIV || state_q == S_BDIV))
		else $error("divider finished outside a division state");

	// The probe only leaves the chain while a search is in progress.
	a_probe_owner: assert property (@(posedge clk) disable iff (!arst_n)
		prb_ctl[MAX_KEYS].live |-> state_q == S_SCAN)
		else $error("probe left the chain outside a search");

	// A full status is only reported when every cell is in use.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && pres_stat_q == ST_FULL) |-> count_q == FULL)
		else $error("full status with free cells");

endmodule
